// File: rtl/reed_solomon_check_symbol_encoder_top_macros.svh
// Assertion macros for the Reed-Solomon check symbol encoder.
`ifndef REED_SOLOMON_CHECK_SYMBOL_ENCODER_TOP_MACROS_SVH
`define REED_SOLOMON_CHECK_SYMBOL_ENCODER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSENC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RSENC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rsenc_pkg.sv
// Shared constants, types and GF(256) arithmetic for the RS check symbol encoder.
package rsenc_pkg;

  localparam int MAX_CHECKS = 68;
  localparam int CNT_W      = 7;
  localparam int PAIR_W     = $clog2(MAX_CHECKS / 2 + 1);
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Field polynomial x^8 + x^5 + x^3 + x^2 + 1, low byte used on reduction
  localparam logic [8:0] FIELD_POLY = 9'h12D;

  // Count of check bytes after reset
  localparam logic [CNT_W-1:0] RESET_CHECK_COUNT = 7'd5;

  // Register index, taken from the word address bit
  localparam logic REG_CHECK_COUNT = 1'b0;

  typedef enum logic {
    ST_BUILD,
    ST_RUN
  } state_t;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic clear_all;   // drop remainder and generator
    logic step_gen;    // one generator multiply step
    logic shift_rem;   // absorb one data byte
    logic clear_rem;   // message end: remainder back to zero
  } cell_ctrl_t;

  // Multiply by alpha (x), reduced by the field polynomial
  function automatic logic [7:0] gf_xtime(input logic [7:0] x);
    logic [7:0] sh;
    sh = {x[6:0], 1'b0};
    return x[7] ? (sh ^ FIELD_POLY[7:0]) : sh;
  endfunction

  // General GF(256) multiply, shift-and-add over the bits of b
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

endpackage

// File: rtl/rsenc_cell.sv
// One cell of the division chain: a remainder byte and a generator coefficient.
module rsenc_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  rsenc_pkg::cell_ctrl_t  ctrl,
  input  logic [7:0]             root,
  input  logic [7:0]             fb,
  input  logic [7:0]             rem_in,
  input  logic [7:0]             coef_in,
  output logic [7:0]             rem,
  output logic [7:0]             rem_next,
  output logic [7:0]             coef
);
  import rsenc_pkg::*;

  logic [7:0] coef_next;

  // Remainder update: neighbor byte plus feedback times this coefficient
  assign rem_next  = rem_in ^ gf_mul(fb, coef);

  // Generator update in reversed order: h[m] ^= root * h[m-1]
  assign coef_next = coef ^ gf_mul(root, coef_in);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_all) begin
      rem  <= '0;
      coef <= '0;
    end else begin
      if (ctrl.step_gen) begin
        coef <= coef_next;
      end
      if (ctrl.clear_rem) begin
        rem <= '0;
      end else if (ctrl.shift_rem) begin
        rem <= rem_next;
      end
    end
  end

endmodule

// File: rtl/reed_solomon_check_symbol_encoder_top.sv
// Top level of the RS check symbol encoder: cell chain, generator build, pair output.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------------------
//   input    | in_valid / in_ready  | data_byte, last_byte
//   output   | out_valid / out_ready| check_first, check_second, second_valid,
//            |                      | last_pair
//   config   | APB psel/penable     | paddr, pwdata, prdata (check_count)
//
// One data byte per cycle while in_ready is high; each cell updates its remainder byte
// in the cycle of acceptance. After reset or a check_count write the generator is built
// by the chain (n = effective check count, 1..68); no input is taken during that time.
// A last byte loads the remainder into an output shift line: (n+1)/2 pairs, one per cycle
// while out_ready is high; data bytes keep flowing, a further last byte waits for the drain.
`include "reed_solomon_check_symbol_encoder_top_macros.svh"

module reed_solomon_check_symbol_encoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rsenc_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsenc_pkg::DATA_W-1:0]  pwdata,
  output logic [rsenc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    check_first,
  output logic [7:0]                    check_second,
  output logic                          second_valid,
  output logic                          last_pair
);
  import rsenc_pkg::*;

  // Clamp a written count into 1..MAX_CHECKS
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (c > CNT_W'(MAX_CHECKS)) begin
      r = CNT_W'(MAX_CHECKS);
    end
    return r;
  endfunction

  logic [CNT_W-1:0]  check_count;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  build_cnt;
  logic [7:0]        root;
  state_t            state, state_next;
  cell_ctrl_t        ctrl;
  logic              cfg_wr;
  logic              in_xact, out_xact;
  logic              drain_free;
  logic [7:0]        fb;
  logic [7:0]        rem_q  [MAX_CHECKS];
  logic [7:0]        rem_nx [MAX_CHECKS];
  logic [7:0]        coef_q [MAX_CHECKS];
  logic [7:0]        osh    [MAX_CHECKS];
  logic [PAIR_W-1:0] pairs_left;
  logic              odd;
  logic [CNT_W:0]    pair_sum;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_CHECK_COUNT);
  assign prdata = (paddr[ADDR_W-1] == REG_CHECK_COUNT) ? DATA_W'(check_count) : '0;
  assign n_eff  = eff_count(check_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      check_count <= RESET_CHECK_COUNT;
    end else if (cfg_wr) begin
      check_count <= pwdata[CNT_W-1:0];
    end
  end

  // Generator build sequencer: state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BUILD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_BUILD: begin
        if (cfg_wr) begin
          state_next = ST_BUILD;
        end else if (build_cnt == CNT_W'(1)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cfg_wr) begin
          state_next = ST_BUILD;
        end
      end
      default: state_next = ST_BUILD;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctrl.clear_all = cfg_wr;
    ctrl.step_gen  = 1'b0;
    in_ready       = 1'b0;
    unique case (state)
      ST_BUILD: begin
        ctrl.step_gen = !cfg_wr;
      end
      ST_RUN: begin
        in_ready = !last_byte || drain_free;
      end
      default: begin
        ctrl.step_gen = 1'b0;
      end
    endcase
    ctrl.shift_rem = in_valid && in_ready;
    ctrl.clear_rem = in_valid && in_ready && last_byte;
  end

  assign in_xact  = in_valid && in_ready;
  assign out_xact = out_valid && out_ready;

  // Build step count and current root alpha^i
  always_ff @(posedge clk) begin
    if (rst) begin
      build_cnt <= eff_count(RESET_CHECK_COUNT);
      root      <= 8'h02;
    end else if (cfg_wr) begin
      build_cnt <= eff_count(pwdata[CNT_W-1:0]);
      root      <= 8'h02;
    end else if (state == ST_BUILD) begin
      build_cnt <= build_cnt - CNT_W'(1);
      root      <= gf_xtime(root);
    end
  end

  // Division chain
  assign fb = rem_q[0] ^ data_byte;

  for (genvar j = 0; j < MAX_CHECKS; j++) begin : g_cell
    logic [7:0] rem_in;
    logic [7:0] coef_in;
    if (j == MAX_CHECKS - 1) begin : g_tail
      assign rem_in = 8'h00;
    end else begin : g_body
      assign rem_in = rem_q[j+1];
    end
    if (j == 0) begin : g_head
      assign coef_in = 8'h01;
    end else begin : g_link
      assign coef_in = coef_q[j-1];
    end
    rsenc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .root     (root),
      .fb       (fb),
      .rem_in   (rem_in),
      .coef_in  (coef_in),
      .rem      (rem_q[j]),
      .rem_next (rem_nx[j]),
      .coef     (coef_q[j])
    );
  end

  // Output drain: room for a new message end this cycle
  assign drain_free = (pairs_left == '0) || ((pairs_left == PAIR_W'(1)) && out_ready);
  assign pair_sum   = {1'b0, n_eff} + (CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_left <= '0;
    end else if (in_xact && last_byte) begin
      pairs_left <= PAIR_W'(pair_sum[CNT_W:1]);
    end else if (out_xact) begin
      pairs_left <= pairs_left - PAIR_W'(1);
    end
  end

  // Output shift line, two bytes per transaction
  always_ff @(posedge clk) begin
    if (in_xact && last_byte) begin
      odd <= n_eff[0];
      for (int j = 0; j < MAX_CHECKS; j++) begin
        osh[j] <= rem_nx[j];
      end
    end else if (out_xact) begin
      for (int j = 0; j < MAX_CHECKS - 2; j++) begin
        osh[j] <= osh[j+2];
      end
      osh[MAX_CHECKS-2] <= 8'h00;
      osh[MAX_CHECKS-1] <= 8'h00;
    end
  end

  assign out_valid    = (pairs_left != '0);
  assign last_pair    = (pairs_left == PAIR_W'(1));
  assign second_valid = !(last_pair && odd);
  assign check_first  = osh[0];
  assign check_second = osh[1];

  // Checks
  `RSENC_ASSERT_NOW(a_no_input_in_build, state == ST_BUILD, !in_ready,
    "input taken while generator is being built")
  `RSENC_ASSERT_NEXT(a_last_starts_drain, in_xact && last_byte,
    out_valid && (pairs_left == $past(PAIR_W'(pair_sum[CNT_W:1]))),
    "message end did not start the pair drain")
  `RSENC_ASSERT_NOW(a_odd_tail_zero, out_valid && !second_valid, check_second == 8'h00,
    "unused second check byte is not zero")

endmodule

// File: tb/sv/reed_solomon_check_symbol_encoder_top_test.sv
// Self-checking testbench for the GF(256) Reed-Solomon check symbol encoder.
module reed_solomon_check_symbol_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rsenc_pkg::*;

  localparam logic [8:0] GF_REDUCE    = 9'h12D;
  localparam int         SETTLE_CYCLES = 80;      // generator build plus output drain
  localparam int         RANDOM_BYTES  = 370;
  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         DIRECTED_LEN  = 27;

  typedef struct packed {
    logic [7:0] check_first;
    logic [7:0] check_second;
    logic       second_valid;
    logic       last_pair;
  } check_pair_t;

  // One directed row: either a count write or one codeword byte
  typedef struct packed {
    logic        is_cfg;
    logic [6:0]  cfg_value;
    logic [7:0]  data;
    logic        last;
    logic        typed;      // expected pair given below instead of predicted
    check_pair_t pair;
  } step_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          data_byte;
  logic                last_byte;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          check_first;
  logic [7:0]          check_second;
  logic                second_valid;
  logic                last_pair;

  reed_solomon_check_symbol_encoder_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .check_first  (check_first),
    .check_second (check_second),
    .second_valid (second_valid),
    .last_pair    (last_pair)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [6:0]   count_reg;
  logic [7:0]   gen_coef  [MAX_CHECKS];
  logic [7:0]   rem_bytes [MAX_CHECKS];
  check_pair_t  pending_pairs [$];

  int unsigned  cycle_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  random_sent = 0;
  logic         idle_off;

  // Stretch of the run with no idling on either side
  assign idle_off = (cycle_count >= 2000) && (cycle_count < 3500);

  step_t directed_steps [DIRECTED_LEN] = '{
    '{1'b0, 7'd0,   8'h00, 1'b1, 1'b0, '0},
    '{1'b0, 7'd0,   8'hFF, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h80, 1'b1, 1'b0, '0},
    '{1'b1, 7'd1,   8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h01, 1'b1, 1'b1, '{8'h02, 8'h00, 1'b0, 1'b1}},
    '{1'b0, 7'd0,   8'h80, 1'b1, 1'b1, '{8'h2D, 8'h00, 1'b0, 1'b1}},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 1'b1, '{8'hD3, 8'h00, 1'b0, 1'b1}},
    '{1'b0, 7'd0,   8'h00, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b0, 1'b1}},
    '{1'b1, 7'd0,   8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h01, 1'b1, 1'b1, '{8'h02, 8'h00, 1'b0, 1'b1}},
    '{1'b1, 7'd2,   8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h00, 1'b1, 1'b1, '{8'h00, 8'h00, 1'b1, 1'b1}},
    '{1'b0, 7'd0,   8'h55, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'hAA, 1'b1, 1'b0, '0},
    '{1'b1, 7'd68,  8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h12, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'hFF, 1'b1, 1'b0, '0},
    '{1'b1, 7'd127, 8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h01, 1'b1, 1'b0, '0},
    '{1'b1, 7'd3,   8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h7E, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h81, 1'b1, 1'b0, '0},
    '{1'b1, 7'd4,   8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h33, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'hC4, 1'b0, 1'b0, '0},
    // count rewritten mid-message: the partial remainder is dropped
    '{1'b1, 7'd4,   8'h00, 1'b0, 1'b0, '0},
    '{1'b0, 7'd0,   8'h01, 1'b1, 1'b0, '0}
  };

  // GF(256) product, shift-and-add with reduction by the field polynomial
  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] x;
    logic [7:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x[7:0];
      end
      x = {x[7:0], 1'b0};
      if (x[8]) begin
        x = x ^ GF_REDUCE;
      end
    end
    return acc;
  endfunction

  // Count in force: 0 acts as 1, anything above the maximum as the maximum
  function automatic int unsigned active_count();
    if (count_reg == 7'd0) begin
      return 1;
    end
    if (int'(count_reg) > MAX_CHECKS) begin
      return MAX_CHECKS;
    end
    return 32'(count_reg);
  endfunction

  // Generator = prod (x + alpha^i), i = 1..n; keeps the n low-order coefficients
  function automatic void rebuild_generator();
    logic [7:0]  poly [MAX_CHECKS+1];
    logic [7:0]  root;
    int unsigned n;
    n = active_count();
    foreach (poly[i]) poly[i] = '0;
    poly[0] = 8'd1;
    root    = 8'd1;
    for (int i = 1; i <= n; i++) begin
      root    = field_mul(root, 8'd2);
      poly[i] = poly[i-1];
      for (int j = i - 1; j >= 1; j--) begin
        poly[j] = poly[j-1] ^ field_mul(poly[j], root);
      end
      poly[0] = field_mul(poly[0], root);
    end
    for (int i = 0; i < MAX_CHECKS; i++) begin
      gen_coef[i]  = (i < n) ? poly[i] : 8'd0;
      rem_bytes[i] = 8'd0;
    end
  endfunction

  // Division step for one byte; on the last byte queue the check pairs if keep_pairs is set
  function automatic void absorb_codeword(input logic [7:0] d, input logic last,
                                          input bit keep_pairs);
    int unsigned n;
    logic [7:0]  k;
    check_pair_t p;
    n = active_count();
    k = rem_bytes[0] ^ d;
    for (int j = 0; j + 1 < n; j++) begin
      rem_bytes[j] = rem_bytes[j+1] ^ field_mul(k, gen_coef[n-1-j]);
    end
    rem_bytes[n-1] = field_mul(k, gen_coef[0]);
    if (last) begin
      for (int r = 0; r < n; r += 2) begin
        p.check_first  = rem_bytes[r];
        p.second_valid = (r + 1 < n);
        p.check_second = p.second_valid ? rem_bytes[r+1] : 8'd0;
        p.last_pair    = (r + 2 >= n);
        if (keep_pairs) begin
          pending_pairs.push_back(p);
        end
      end
      foreach (rem_bytes[i]) rem_bytes[i] = 8'd0;
    end
  endfunction

  // Send one byte; entered and left at a falling edge
  task automatic send_codeword(input logic [7:0] d, input logic last,
                               input logic typed, input check_pair_t typed_pair);
    int unsigned gap;
    gap = 0;
    while (!idle_off && $urandom_range(0, 99) < 25) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= d;
    last_byte <= last;
    do @(posedge clk); while (!in_ready);
    absorb_codeword(d, last, !typed);
    if (typed) begin
      pending_pairs.push_back(typed_pair);
    end
    @(negedge clk);
  endtask

  // Count write while the encoder is idle; entered and left at a falling edge
  task automatic write_check_count(input logic [6:0] value);
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CHECK_COUNT, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_reg = value;
    rebuild_generator();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: random back-pressure, none during the idle_off stretch
  always @(negedge clk) begin
    out_ready <= idle_off ? 1'b1 : ($urandom_range(0, 99) >= 25);
  end

  // Compare each accepted pair with the oldest expectation
  always @(posedge clk) begin
    check_pair_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $error("check pair with no expectation: first %0h second %0h",
               check_first, check_second);
        mismatch_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (check_first !== want.check_first) begin
          $error("check_first: expected %0h, got %0h", want.check_first, check_first);
          mismatch_count++;
        end
        if (check_second !== want.check_second) begin
          $error("check_second: expected %0h, got %0h", want.check_second, check_second);
          mismatch_count++;
        end
        if (second_valid !== want.second_valid) begin
          $error("second_valid: expected %0b, got %0b", want.second_valid, second_valid);
          mismatch_count++;
        end
        if (last_pair !== want.last_pair) begin
          $error("last_pair: expected %0b, got %0b", want.last_pair, last_pair);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Stimulus
  initial begin
    logic [6:0]  cfg;
    int unsigned msgs;
    int unsigned len;
    bit          cut;
    logic [7:0]  d;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    count_reg = RESET_CHECK_COUNT;
    rebuild_generator();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        write_check_count(directed_steps[i].cfg_value);
      end else begin
        send_codeword(directed_steps[i].data, directed_steps[i].last,
                      directed_steps[i].typed, directed_steps[i].pair);
      end
    end

    // Random phases: pick a count, then a few messages of random bytes
    while (random_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0:       cfg = 7'd68;
        1:       cfg = 7'($urandom_range(69, 127));
        2:       cfg = 7'd0;
        3:       cfg = 7'($urandom_range(17, 67));
        default: cfg = 7'($urandom_range(1, 16));
      endcase
      write_check_count(cfg);
      msgs = $urandom_range(2, 6);
      for (int m = 0; m < msgs; m++) begin
        len = $urandom_range(1, 10);
        // now and then the phase ends with a message left unfinished
        cut = (m == msgs - 1) && ($urandom_range(0, 9) == 0);
        for (int b = 0; b < len; b++) begin
          d = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
          send_codeword(d, (b == len - 1) && !cut, 1'b0, '0);
          random_sent++;
        end
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
